[design/assert_macros.svh]
// ------------------------------------------------------------------
// assert_macros: shared concurrent assertion macros
// clocked, active-low reset disables the check
// ------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// overlapping implication
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[design/ccps_pkg.sv]
// ------------------------------------------------------------------
// ccps_pkg
// types, constants and fp helpers of the column prefix sum block
// ------------------------------------------------------------------
package ccps_pkg;

    localparam int KeyDimDef   = 128;
    localparam int MaxHeadsDef = 16;
    localparam int MaxChunkDef = 128;

    localparam int HeadsW   = 5;
    localparam int ChunkW   = 8;
    localparam int CfgDataW = 8;
    localparam int ColOutW  = 11;
    localparam int RowOutW  = 7;

    localparam logic [31:0] QNanBits = 32'h7FC0_0000;

    typedef enum logic [0:0] {
        REG_NUM_HEADS  = 1'b0,
        REG_CHUNK_SIZE = 1'b1
    } t_reg_idx;

    typedef logic [ColOutW-1:0] t_col_out;
    typedef logic [RowOutW-1:0] t_row_out;

    typedef struct packed {
        logic [15:0] gate_half;
        logic        first_of_sequence;
    } t_in_item;

    typedef struct packed {
        logic [31:0] sum_bits;
        t_col_out    column_index;
        t_row_out    row_in_chunk;
    } t_out_item;

    // exact fp16 -> fp32 widening, nan keeps payload and turns quiet
    function automatic logic [31:0] half_to_single(input logic [15:0] h);
        logic [4:0]  ex;
        logic [9:0]  man;
        logic [7:0]  e;
        logic [9:0]  m;
        logic [31:0] res;
        logic        found;
        ex    = h[14:10];
        man   = h[9:0];
        e     = 8'd0;
        m     = 10'd0;
        found = 1'b0;
        if (ex == 5'h1F) begin
            res = {h[15], 8'hFF, man, 13'd0};
            if (man != 10'd0) begin
                res[22] = 1'b1;
            end
        end else if (ex == 5'd0) begin
            if (man == 10'd0) begin
                res = {h[15], 31'd0};
            end else begin
                // normalize on the leading one
                for (int p = 9; p >= 0; p--) begin
                    if (!found && man[p]) begin
                        found = 1'b1;
                        e     = 8'(103 + p);
                        m     = 10'(man << (10 - p));
                    end
                end
                res = {h[15], e, m, 13'd0};
            end
        end else begin
            res = {h[15], 8'({3'd0, ex} + 8'd112), man, 13'd0};
        end
        return res;
    endfunction

    // leading zero count over 27 bits, 27 when all zero
    function automatic logic [4:0] lzc27(input logic [26:0] v);
        logic [4:0] n;
        logic       found;
        n     = 5'd27;
        found = 1'b0;
        for (int i = 26; i >= 0; i--) begin
            if (!found && v[i]) begin
                found = 1'b1;
                n     = 5'(26 - i);
            end
        end
        return n;
    endfunction

endpackage

[design/ccps_stream_if.sv]
// ------------------------------------------------------------------
// ccps_stream_if
// valid/ready channel carrying one item per handshake
// ------------------------------------------------------------------
interface ccps_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[design/ccps_ram.sv]
// ------------------------------------------------------------------
// ccps_ram
// single-port-write, single-port-read ram with registered read
// ------------------------------------------------------------------
module ccps_ram #(
    parameter int Width = 32,
    parameter int Depth = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

[design/ccps_fadd.sv]
// ------------------------------------------------------------------
// ccps_fadd
// three-stage fp32 adder, round to nearest even, canonical nan
// ------------------------------------------------------------------
module ccps_fadd (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [31:0] o_sum
);
    localparam logic [31:0] QNanBitsL = ccps_pkg::QNanBits;

    // stage a: unpack, swap, align, add
    logic [7:0]  ea, eb, eae, ebe;
    logic [23:0] ma, mb, m_big, m_sml;
    logic        a_big, s_big, s_sml;
    logic [7:0]  e_big, d;
    logic [26:0] ext, shf, mask;
    logic        sticky, nan_a, nan_b, inf_a, inf_b;
    logic [27:0] sum_a;

    logic [27:0] r_sum;
    logic [7:0]  r_exp;
    logic        r_sign, r_sub, r_nan, r_inf, r_inf_s;

    always_comb begin
        ea    = i_a[30:23];
        eb    = i_b[30:23];
        eae   = (ea == 8'd0) ? 8'd1 : ea;
        ebe   = (eb == 8'd0) ? 8'd1 : eb;
        ma    = {ea != 8'd0, i_a[22:0]};
        mb    = {eb != 8'd0, i_b[22:0]};
        nan_a = (ea == 8'hFF) && (i_a[22:0] != 23'd0);
        nan_b = (eb == 8'hFF) && (i_b[22:0] != 23'd0);
        inf_a = (ea == 8'hFF) && (i_a[22:0] == 23'd0);
        inf_b = (eb == 8'hFF) && (i_b[22:0] == 23'd0);
        a_big = {eae, ma} >= {ebe, mb};
        e_big = a_big ? eae : ebe;
        m_big = a_big ? ma : mb;
        m_sml = a_big ? mb : ma;
        s_big = a_big ? i_a[31] : i_b[31];
        s_sml = a_big ? i_b[31] : i_a[31];
        d     = e_big - (a_big ? ebe : eae);
        ext   = {m_sml, 3'd0};
        mask  = '0;
        if (d >= 8'd27) begin
            shf    = 27'd0;
            sticky = |m_sml;
        end else begin
            mask   = ~(27'h7FF_FFFF << d[4:0]);
            shf    = ext >> d[4:0];
            sticky = |(ext & mask);
        end
        shf[0] = shf[0] | sticky;
        if (s_big ^ s_sml) begin
            sum_a = {1'b0, m_big, 3'd0} - {1'b0, shf};
        end else begin
            sum_a = {1'b0, m_big, 3'd0} + {1'b0, shf};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum   <= sum_a;
            r_exp   <= e_big;
            r_sign  <= s_big;
            r_sub   <= s_big ^ s_sml;
            r_nan   <= nan_a || nan_b || (inf_a && inf_b && (i_a[31] != i_b[31]));
            r_inf   <= inf_a || inf_b;
            r_inf_s <= inf_a ? i_a[31] : i_b[31];
        end
    end

    // stage b: normalize, left shift held at the subnormal boundary
    logic [4:0]  lz;
    logic [8:0]  lim, sh, e_n;
    logic [26:0] m_n;
    logic        zero_b;

    logic [26:0] r_m;
    logic [8:0]  r_e;
    logic        r_sign2, r_nan2, r_inf2;

    always_comb begin
        zero_b = (r_sum == 28'd0);
        lz     = ccps_pkg::lzc27(r_sum[26:0]);
        lim    = {1'b0, r_exp} - 9'd1;
        sh     = ({4'd0, lz} < lim) ? {4'd0, lz} : lim;
        if (r_sum[27]) begin
            m_n = {r_sum[27:2], r_sum[1] | r_sum[0]};
            e_n = {1'b0, r_exp} + 9'd1;
        end else begin
            m_n = r_sum[26:0] << sh;
            e_n = {1'b0, r_exp} - sh;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m     <= m_n;
            r_e     <= e_n;
            // exact cancellation gives +0
            r_sign2 <= r_inf ? r_inf_s : ((zero_b && r_sub) ? 1'b0 : r_sign);
            r_nan2  <= r_nan;
            r_inf2  <= r_inf;
        end
    end

    // stage c: round and pack
    logic        up;
    logic [24:0] mr;
    logic [23:0] mant;
    logic [8:0]  e_r;
    logic [31:0] res;

    always_comb begin
        up = r_m[2] && (r_m[1] || r_m[0] || r_m[3]);
        mr = {1'b0, r_m[26:3]} + {24'd0, up};
        if (mr[24]) begin
            mant = mr[24:1];
            e_r  = r_e + 9'd1;
        end else begin
            mant = mr[23:0];
            e_r  = r_e;
        end
        if (r_nan2) begin
            res = QNanBitsL;
        end else if (r_inf2 || (e_r >= 9'd255)) begin
            res = {r_sign2, 8'hFF, 23'd0};
        end else begin
            res = {r_sign2, (mant[23] ? e_r[7:0] : 8'd0), mant[22:0]};
        end
    end

    logic [31:0] r_res;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res <= res;
        end
    end

    assign o_sum = r_res;
endmodule

[design/chunked_column_prefix_sum.sv]
// ------------------------------------------------------------------
// chunked_column_prefix_sum
// fp16 column stream in, running fp32 column sums out, per chunk
// ------------------------------------------------------------------
// Takes one item per cycle unless the output stalls and gives one result per
// item through r_v1, r_va, r_vb and r_vo. The column accumulators sit in
// one ram read at acceptance and written back when the sum reaches the output
// register; the fp32 adder is three stages. A stall on the output holds the
// whole pipe. A column comes back at least one row width (KeyDim or more
// items) later, beyond the depth of the pipe, so no forwarding is needed.
module chunked_column_prefix_sum #(
    parameter int KeyDim   = ccps_pkg::KeyDimDef,
    parameter int MaxHeads = ccps_pkg::MaxHeadsDef,
    parameter int MaxChunk = ccps_pkg::MaxChunkDef
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [0:0]                    i_cfg_idx,
    input  logic [ccps_pkg::CfgDataW-1:0] i_cfg_data,
    ccps_stream_if.sink                   i_in,
    ccps_stream_if.source                 o_out
);
    localparam int Depth = MaxHeads * KeyDim;
    localparam int AW    = $clog2(Depth);
    localparam int CW    = $clog2(Depth + 1);
    localparam int RW    = $clog2(MaxChunk + 1);

    typedef logic [CW-1:0] t_col;
    typedef logic [RW-1:0] t_row;

    // config, held clamped
    logic [CW-1:0] r_width, n_width;
    logic [RW-1:0] r_chunk, n_chunk;
    logic [ccps_pkg::HeadsW-1:0] heads;
    logic [ccps_pkg::ChunkW-1:0] chunk;

    always_comb begin
        heads   = ccps_pkg::HeadsW'(i_cfg_data);
        chunk   = ccps_pkg::ChunkW'(i_cfg_data);
        n_width = r_width;
        n_chunk = r_chunk;
        if (i_cfg_we && (ccps_pkg::t_reg_idx'(i_cfg_idx) == ccps_pkg::REG_NUM_HEADS)) begin
            if (heads == '0) begin
                n_width = CW'(KeyDim);
            end else if (int'(heads) > MaxHeads) begin
                n_width = CW'(Depth);
            end else begin
                n_width = CW'(int'(heads) * KeyDim);
            end
        end
        if (i_cfg_we && (ccps_pkg::t_reg_idx'(i_cfg_idx) == ccps_pkg::REG_CHUNK_SIZE)) begin
            if (chunk == '0) begin
                n_chunk = RW'(1);
            end else if (int'(chunk) > MaxChunk) begin
                n_chunk = RW'(MaxChunk);
            end else begin
                n_chunk = RW'(chunk);
            end
        end
    end

    // pipe control
    logic adv, acc;
    logic r_v1, r_va, r_vb, r_vo;
    assign adv        = !r_vo || o_out.ready;
    assign acc        = i_in.valid && adv;
    assign i_in.ready = adv;

    // position counters
    t_col r_col, n_col, c;
    t_row r_row, n_row, r;

    always_comb begin
        c     = i_in.data.first_of_sequence ? '0 : r_col;
        r     = i_in.data.first_of_sequence ? '0 : r_row;
        if (c >= r_width) begin
            c = '0;
            r = r + t_row'(1);
        end
        if (r >= r_chunk) begin
            r = '0;
        end
        n_col = r_col;
        n_row = r_row;
        if (acc) begin
            n_col = c + t_col'(1);
            n_row = r;
            if (n_col >= r_width) begin
                n_col = '0;
                n_row = (r + t_row'(1) >= r_chunk) ? '0 : r + t_row'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= CW'(KeyDim);
            r_chunk <= (MaxChunk < 64) ? RW'(MaxChunk) : RW'(64);
            r_col   <= '0;
            r_row   <= '0;
            r_v1    <= 1'b0;
            r_va    <= 1'b0;
            r_vb    <= 1'b0;
            r_vo    <= 1'b0;
        end else begin
            r_width <= n_width;
            r_chunk <= n_chunk;
            r_col   <= n_col;
            r_row   <= n_row;
            if (adv) begin
                r_v1 <= acc;
                r_va <= r_v1;
                r_vb <= r_va;
                r_vo <= r_vb;
            end
        end
    end

    // payload pipe
    logic [31:0] r_x1;
    t_col        r_c1, r_ca, r_cb, r_co;
    t_row        r_r1, r_ra, r_rb, r_ro;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_x1 <= ccps_pkg::half_to_single(i_in.data.gate_half);
            r_c1 <= c;
            r_r1 <= r;
            r_ca <= r_c1;
            r_ra <= r_r1;
            r_cb <= r_ca;
            r_rb <= r_ra;
            r_co <= r_cb;
            r_ro <= r_rb;
        end
    end

    logic [31:0] rdata, acc_in, sum;

    ccps_ram #(
        .Width (32),
        .Depth (Depth)
    ) u_sums (
        .i_clk   (i_clk),
        .i_we    (r_vo),
        .i_waddr (AW'(r_co)),
        .i_wdata (sum),
        .i_re    (adv),
        .i_raddr (AW'(c)),
        .o_rdata (rdata)
    );

    // first row of a chunk: add -0, which leaves any value but a nan as it is
    assign acc_in = (r_r1 == '0) ? 32'h8000_0000 : rdata;

    ccps_fadd u_fadd (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_a   (acc_in),
        .i_b   (r_x1),
        .o_sum (sum)
    );

    assign o_out.valid = r_vo;
    assign o_out.data  = '{
        sum_bits:     sum,
        column_index: ccps_pkg::t_col_out'(r_co),
        row_in_chunk: ccps_pkg::t_row_out'(r_ro)
    };
endmodule

[design/ccps_checker.sv]
// ------------------------------------------------------------------
// ccps_checker
// port-level checks of the column prefix sum block
// ------------------------------------------------------------------
`include "assert_macros.svh"

module ccps_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_first,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_sum,
    input logic [10:0] i_col,
    input logic [6:0]  i_row
);
    logic acc;
    assign acc = i_in_valid && i_in_ready;

    // empty output register never blocks the input
    `ASSERT_IMPLIES(a_ready_when_empty, i_clk, i_rst_n, !i_out_valid, i_in_ready)

    // stalled result holds
    `ASSERT_NEXT(a_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_sum) && $stable(i_col) && $stable(i_row))

    // a sequence start comes out at row 0 column 0 while the output is not stalled
    `ASSERT_IMPLIES(a_seq_start, i_clk, i_rst_n, acc && i_first ##1 i_out_ready ##1 i_out_ready ##1 i_out_ready, ##1 (i_out_valid && (i_col == '0) && (i_row == '0)))
endmodule

bind chunked_column_prefix_sum ccps_checker u_ccps_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_first     (i_in.data.first_of_sequence),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_sum       (o_out.data.sum_bits),
    .i_col       (o_out.data.column_index),
    .i_row       (o_out.data.row_in_chunk)
);
